// ----- rtl/e2c_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_pkg - shared types and constants for the epoch to calendar converter
// Sequencer states, fixed calendar constants and the month length table.
// ----------------------------------------------------------------------------
package e2c_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAY,
    ST_PREP,
    ST_SPLIT,
    ST_YEAR,
    ST_TAIL,
    ST_FIN
  } e2c_state_t;

  // Serial divisors
  localparam int unsigned DaySecs   = 86400;
  localparam int unsigned MinSecs   = 60;
  localparam int unsigned BlockDays = 1461;   // four years, first one leap
  localparam int unsigned WeekDays  = 7;

  // Serial pass bounds for the step counter (one dividend bit per cycle)
  localparam logic [4:0] DayLast   = 5'd31;   // 32-bit seconds count
  localparam logic [4:0] SplitLast = 5'd16;   // 17-bit day and second values
  localparam logic [4:0] TailLast  = 5'd11;   // month walk, worst case
  localparam logic [4:0] MinBits   = 5'd11;   // minute of day
  localparam logic [4:0] DoyBits   = 5'd9;    // day of year

  // Four-year blocks count from 1968-01-01
  localparam logic [11:0] BaseYear   = 12'd1968;
  localparam logic [16:0] EpochShift = 17'd731;    // 1968-01-01 to 1970-01-01
  // 2100 is not leap: from 2100-03-01 on, one phantom day is inserted
  localparam logic [15:0] SkipDay    = 16'd47541;  // 2100-03-01 in epoch days
  localparam logic [11:0] SkipYear   = 12'd2100;
  localparam logic [8:0]  PhantomDoy = 9'd60;      // zero-based doy just after the phantom Feb 29

  // Year starts inside a block
  localparam logic [10:0] Year1Start = 11'd366;
  localparam logic [10:0] Year2Start = 11'd731;
  localparam logic [10:0] Year3Start = 11'd1096;

  // Month codes
  localparam logic [3:0] MonFeb = 4'd1;
  localparam logic [3:0] MonMar = 4'd2;
  localparam logic [3:0] MonApr = 4'd3;
  localparam logic [3:0] MonJun = 4'd5;
  localparam logic [3:0] MonSep = 4'd8;
  localparam logic [3:0] MonOct = 4'd9;
  localparam logic [3:0] MonNov = 4'd10;
  localparam logic [3:0] MonDec = 4'd11;

  localparam logic [2:0] Sunday      = 3'd6;
  localparam logic [2:0] EpochWday   = 3'd3;   // 1970-01-01 was a Thursday
  localparam logic [8:0] LongMonLast = 9'd30;  // last zero-based day of a 31-day month

  // Days in a month
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    unique case (mon)
      MonFeb:                         len = leap ? 5'd29 : 5'd28;
      MonApr, MonJun, MonSep, MonNov: len = 5'd30;
      default:                        len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/e2c_sdiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_sdiv - bit-serial restoring divider by a constant
// Takes one dividend bit per cycle while step is high, MSB first; emits one
// quotient bit per cycle and keeps the running remainder.
// ----------------------------------------------------------------------------
module e2c_sdiv #(
  parameter int unsigned DIV = 7
) (
  input  logic                     clk,
  input  logic                     clr,
  input  logic                     step,
  input  logic                     dbit,
  output logic                     qbit,
  output logic [$clog2(DIV)-1:0]   rem
);

  localparam int unsigned RW   = $clog2(DIV);
  localparam logic [RW:0] DivC = (RW + 1)'(DIV);

  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW:0]   cand;

  // shift in one bit, subtract the divisor when it fits
  assign cand = {rem_r, dbit};
  assign qbit = (cand >= DivC);
  assign rem  = rem_r;

  always_comb begin
    rem_nxt = rem_r;
    if (clr) begin
      rem_nxt = '0;
    end else if (step) begin
      rem_nxt = qbit ? RW'(cand - DivC) : cand[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

endmodule

// ----- rtl/epoch_to_calendar_dst_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_to_calendar_dst_unit - epoch seconds to civil UTC date with UK DST
// Input word: 32-bit seconds since 1970-01-01 00:00 UTC. Output word: time of
// day, date, weekday, week of year, year and a day-granular summer-time flag.
//
// Usage:
//  - in_* channel takes one word when in_tvalid and in_tready are high.
//    in_tready is high only while the converter is idle.
//  - out_* channel holds the result in an output register until taken.
//  - A new word is accepted only after the last result has been loaded into
//    the output register, so one word is converted at a time.
//  - The conversion runs as bit-serial division: seconds by 86400 first,
//    then seconds/60, days/1461 and days mod 7 side by side, then
//    minutes/60, day-of-year/7 and the month walk together.
//  - If the receiver stalls, the result waits in the output register and the
//    next word is still accepted and converted; it waits in its last step
//    until the output register frees.
//  - Reset (rst_n low, synchronous) returns to idle and drops out_tvalid.
// ----------------------------------------------------------------------------
module epoch_to_calendar_dst_unit
  import e2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] epoch_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
  // [25:17] day_in_year, [30:26] day_in_month, [33:31] weekday,
  // [37:34] month_index, [43:38] week_in_year, [44] summer_time,
  // [56:45] calendar_year, [63:57] zero
  output logic [63:0] out_tdata
);

  e2c_state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  // serial datapath
  logic [31:0] sh_a_r;
  logic [16:0] sh_b_r, sh_c_r;
  logic [15:0] days_r;
  logic [10:0] qmin_r;
  logic [5:0]  qblk_r;
  logic [4:0]  qhr_r;
  logic [5:0]  qwk_r;
  logic [5:0]  sec_r;
  logic [2:0]  wd_r;
  logic [11:0] year_r;
  logic        leap_r;
  logic [8:0]  doy_r;
  logic [8:0]  mrem_r;
  logic [3:0]  month_r;

  logic        out_tvalid_r;
  logic [63:0] out_tdata_r;

  logic in_acc, out_load;
  logic day_step, sixty_step, seven_step, blk_step;
  logic sixty_clr, seven_clr;
  logic day_q, sixty_q, blk_q, seven_q;
  logic [16:0] day_rem;
  logic [5:0]  sixty_rem;
  logic [10:0] blk_rem;
  logic [2:0]  seven_rem;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // ---------------- serial dividers ----------------
  e2c_sdiv #(.DIV(DaySecs)) u_day (
    .clk(clk), .clr(in_acc), .step(day_step), .dbit(sh_a_r[31]),
    .qbit(day_q), .rem(day_rem)
  );

  e2c_sdiv #(.DIV(MinSecs)) u_sixty (
    .clk(clk), .clr(sixty_clr), .step(sixty_step), .dbit(sh_a_r[31]),
    .qbit(sixty_q), .rem(sixty_rem)
  );

  e2c_sdiv #(.DIV(BlockDays)) u_blk (
    .clk(clk), .clr(in_acc), .step(blk_step), .dbit(sh_b_r[16]),
    .qbit(blk_q), .rem(blk_rem)
  );

  e2c_sdiv #(.DIV(WeekDays)) u_seven (
    .clk(clk), .clr(seven_clr), .step(seven_step), .dbit(sh_c_r[16]),
    .qbit(seven_q), .rem(seven_rem)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    day_step   = 1'b0;
    blk_step   = 1'b0;
    sixty_step = 1'b0;
    seven_step = 1'b0;
    sixty_clr  = in_acc;
    seven_clr  = in_acc;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) state_nxt = ST_DAY;
      end
      ST_DAY: begin
        day_step = 1'b1;
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == DayLast) begin
          state_nxt = ST_PREP;
          cnt_nxt   = '0;
        end
      end
      ST_PREP: begin
        state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        blk_step   = 1'b1;
        sixty_step = 1'b1;
        seven_step = 1'b1;
        cnt_nxt    = cnt_r + 5'd1;
        if (cnt_r == SplitLast) begin
          state_nxt = ST_YEAR;
          cnt_nxt   = '0;
        end
      end
      ST_YEAR: begin
        sixty_clr = 1'b1;
        seven_clr = 1'b1;
        state_nxt = ST_TAIL;
      end
      ST_TAIL: begin
        sixty_step = (cnt_r < MinBits);
        seven_step = (cnt_r < DoyBits);
        cnt_nxt    = cnt_r + 5'd1;
        if (cnt_r == TailLast) begin
          state_nxt = ST_FIN;
          cnt_nxt   = '0;
        end
      end
      ST_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- year split from the four-year block ----------------
  logic [16:0] dadj;
  logic [1:0]  yib;
  logic [10:0] ybase;
  logic [8:0]  rr;
  logic [11:0] yr;
  logic        is_skip;
  logic [8:0]  doy_c;
  logic        leap_c;

  // days since 1968-01-01, with a phantom Feb 29 in 2100
  assign dadj = 17'(days_r) + EpochShift + 17'(days_r >= SkipDay);

  always_comb begin
    priority if (blk_rem >= Year3Start) begin
      yib = 2'd3; ybase = Year3Start;
    end else if (blk_rem >= Year2Start) begin
      yib = 2'd2; ybase = Year2Start;
    end else if (blk_rem >= Year1Start) begin
      yib = 2'd1; ybase = Year1Start;
    end else begin
      yib = 2'd0; ybase = '0;
    end
  end

  assign rr      = 9'(blk_rem - ybase);
  assign yr      = BaseYear + 12'({qblk_r, 2'b00}) + 12'(yib);
  assign is_skip = (yr == SkipYear);
  assign doy_c   = (is_skip && rr >= PhantomDoy) ? rr - 9'd1 : rr;
  assign leap_c  = (yib == 2'd0) && !is_skip;

  // ---------------- month walk ----------------
  logic [4:0] mlen;
  logic       m_stop;

  assign mlen   = month_len(month_r, leap_r);
  assign m_stop = (mrem_r < 9'(mlen)) || (month_r == MonDec);

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) sh_a_r <= in_tdata;
      end
      ST_DAY: begin
        sh_a_r <= {sh_a_r[30:0], 1'b0};
        days_r <= {days_r[14:0], day_q};
      end
      ST_PREP: begin
        sh_a_r <= {day_rem, 15'd0};
        sh_b_r <= dadj;
        sh_c_r <= 17'(days_r) + 17'(EpochWday);
      end
      ST_SPLIT: begin
        sh_a_r <= {sh_a_r[30:0], 1'b0};
        sh_b_r <= {sh_b_r[15:0], 1'b0};
        sh_c_r <= {sh_c_r[15:0], 1'b0};
        qmin_r <= {qmin_r[9:0], sixty_q};
        qblk_r <= {qblk_r[4:0], blk_q};
      end
      ST_YEAR: begin
        sec_r   <= sixty_rem;
        wd_r    <= seven_rem;
        year_r  <= yr;
        leap_r  <= leap_c;
        doy_r   <= doy_c;
        mrem_r  <= doy_c;
        month_r <= '0;
        sh_a_r  <= {qmin_r, 21'd0};
        sh_c_r  <= {doy_c, 8'd0};
      end
      ST_TAIL: begin
        sh_a_r <= {sh_a_r[30:0], 1'b0};
        sh_c_r <= {sh_c_r[15:0], 1'b0};
        if (cnt_r < MinBits) qhr_r <= {qhr_r[3:0], sixty_q};
        if (cnt_r < DoyBits) qwk_r <= {qwk_r[4:0], seven_q};
        if (!m_stop) begin
          mrem_r  <= mrem_r - 9'(mlen);
          month_r <= month_r + 4'd1;
        end
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------- summer-time flag ----------------
  logic [3:0] to_sun;
  logic       last_sun_passed;
  logic       dst;

  assign to_sun          = (wd_r < Sunday) ? 4'(Sunday - wd_r) : 4'd7;
  assign last_sun_passed = (mrem_r + 9'(to_sun)) > LongMonLast;

  always_comb begin
    priority if (month_r == MonMar) begin
      dst = last_sun_passed;
    end else if (month_r == MonOct) begin
      dst = !last_sun_passed;
    end else begin
      dst = (month_r >= MonApr) && (month_r <= MonSep);
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {7'd0, year_r, dst, qwk_r, month_r, wd_r,
                      5'(mrem_r + 9'd1), doy_r, qhr_r, sixty_rem, sec_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- rtl/e2c_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_checker - port-level checks for epoch_to_calendar_dst_unit
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module e2c_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // a stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again while converting");

  // padding above the last field stays zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:57] == 7'd0)
    else $error("nonzero padding in result word");

  // time of day, day of month, weekday and month within their ranges
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:0] < 6'd60 && out_tdata[11:6] < 6'd60 &&
                   out_tdata[16:12] < 5'd24 && out_tdata[30:26] != 5'd0 &&
                   out_tdata[33:31] < 3'd7 && out_tdata[37:34] < 4'd12)
    else $error("result field out of range");

endmodule

bind epoch_to_calendar_dst_unit e2c_checker u_e2c_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
